@@ rtl/hgp_pkg.sv @@
// Shared types, constants and helpers for the HSV gradient pattern generator.
`timescale 1ns / 1ps
`default_nettype none

package hgp_pkg;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION   = 2'd2;

  localparam logic [CFG_W-1:0] RST_LINE_WIDTH   = 13'd800;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd200;
  localparam logic [CFG_W-1:0] RST_SATURATION   = 13'd4096;

  // largest size a 13-bit size register can hold
  localparam int DIM_CAP = 8191;

  localparam int               Q12_W    = 13;
  localparam logic [Q12_W-1:0] Q12_ONE  = 13'd4096;
  localparam int               QUO_W    = 15;
  localparam logic [QUO_W-1:0] HUE_SPAN = 15'd24576;
  localparam logic [11:0]      V_DROP   = 12'd2458;

  typedef struct packed {
    logic eol;
    logic eof;
  } flags_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV_H,
    BK_DIV_V,
    BK_MUL_C,
    BK_MUL_MID,
    BK_EMIT
  } bk_state_t;

  // round(a * 255 / 4096), half up
  function automatic logic [7:0] to_byte(input logic [Q12_W-1:0] a);
    logic [19:0] t;
    t = ({7'd0, a} << 8) - {7'd0, a} + 20'd2048;
    return t[19:12];
  endfunction

endpackage

`default_nettype wire

@@ rtl/hgp_ifs.sv @@
// Valid/ready channel interfaces for the request and pixel streams.
`timescale 1ns / 1ps
`default_nettype none

interface hgp_in_if;
  logic valid;
  logic ready;
  logic restart_frame;
  modport source (output valid, output restart_frame, input ready);
  modport sink   (input valid, input restart_frame, output ready);
endinterface

interface hgp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       end_of_line;
  logic       end_of_frame;
  modport source (output valid, output red, output green, output blue,
                  output end_of_line, output end_of_frame, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input end_of_line, input end_of_frame, output ready);
endinterface

`default_nettype wire

@@ rtl/hgp_fifo.sv @@
// Small register queue between the raster front end and the color back end.
`timescale 1ns / 1ps
`default_nettype none

module hgp_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  output logic          valid,
  input  logic          pop,
  output logic [DW-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hgp_front.sv @@
// Front end: takes requests, keeps the raster position and queues pixel coordinates.
`timescale 1ns / 1ps
`default_nettype none

module hgp_front import hgp_pkg::*; #(
  parameter int XW = 12,
  parameter int YW = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  hgp_in_if.sink            in_chan,
  input  logic [XW-1:0]     wm1,
  input  logic [YW-1:0]     hm1,
  input  logic              q_full,
  output logic              q_push,
  output logic [XW+YW+1:0]  q_wdata
);

  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;
  logic [XW-1:0] xs, x;
  logic [YW-1:0] ys, y;
  flags_t        flags;
  logic          xfer;

  assign in_chan.ready = !q_full;
  assign xfer          = in_chan.valid && !q_full;
  assign q_push        = xfer;

  always_comb begin
    xs        = in_chan.restart_frame ? '0 : col_r;
    ys        = in_chan.restart_frame ? '0 : row_r;
    x         = (xs > wm1) ? wm1 : xs;
    y         = (ys > hm1) ? hm1 : ys;
    flags.eol = (x == wm1);
    flags.eof = flags.eol && (y == hm1);
    q_wdata   = {x, y, flags};

    col_nxt = col_r;
    row_nxt = row_r;
    if (xfer) begin
      if (flags.eol) begin
        col_nxt = '0;
        row_nxt = flags.eof ? '0 : y + 1'b1;
      end else begin
        col_nxt = x + 1'b1;
        row_nxt = y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hgp_div.sv @@
// Restoring divider, one quotient bit per cycle; quotient known to fit QW bits.
`timescale 1ns / 1ps
`default_nettype none

module hgp_div #(
  parameter int RW  = 27,
  parameter int DVW = 12,
  parameter int QW  = 15
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [RW-1:0]  num,
  input  logic [DVW-1:0] den,
  output logic           done,
  output logic [QW-1:0]  quo
);

  localparam int CNTW = $clog2(QW);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [RW-1:0]   rem_r;
  logic [RW-1:0]   dsh_r;
  logic [QW-1:0]   quo_r;
  logic            ge;

  assign ge   = (rem_r >= dsh_r);
  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNTW'(QW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= RW'(den) << (QW - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ rtl/hgp_back.sv @@
// Back end: hue and value division, HSV to RGB math and the output register.
`timescale 1ns / 1ps
`default_nettype none

module hgp_back import hgp_pkg::*; #(
  parameter int XW  = 12,
  parameter int YW  = 12,
  parameter int DVW = 12,
  parameter int RW  = 27
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  logic [XW+YW+1:0]  q_rdata,
  output logic              q_pop,
  input  logic [XW-1:0]     wm1,
  input  logic [YW-1:0]     hm1,
  input  logic [Q12_W-1:0]  sat,
  hgp_out_if.source         out_chan
);

  bk_state_t state_r, state_nxt;

  logic [XW-1:0]    qx;
  logic [YW-1:0]    qy;
  flags_t           qf;
  logic [YW-1:0]    y_r;
  flags_t           flags_r;
  logic [QUO_W-1:0] h6_r;
  logic [Q12_W-1:0] v_r, c_r, m_r, mid_r;

  logic             div_start;
  logic [RW-1:0]    div_num;
  logic [DVW-1:0]   div_den;
  logic             div_done;
  logic [QUO_W-1:0] div_quo;

  logic             ld_item, ld_h6, ld_v, ld_c, ld_mid, ld_out;
  logic             out_free;
  logic [2*Q12_W-1:0] prod_c, prod_m;
  logic [Q12_W-1:0] fsel;
  logic [Q12_W-1:0] r1, g1, b1;

  logic             out_valid_r;
  logic [7:0]       red_r, green_r, blue_r;
  flags_t           oflags_r;

  assign qx = q_rdata[XW+YW+1 -: XW];
  assign qy = q_rdata[YW+1 -: YW];
  assign qf = flags_t'(q_rdata[1:0]);

  assign out_free = !out_valid_r || out_chan.ready;

  hgp_div #(.RW(RW), .DVW(DVW), .QW(QUO_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_num   = (RW'(qx) << 14) + (RW'(qx) << 13);
    div_den   = DVW'(wm1);
    ld_item   = 1'b0;
    ld_h6     = 1'b0;
    ld_v      = 1'b0;
    ld_c      = 1'b0;
    ld_mid    = 1'b0;
    ld_out    = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          ld_item   = 1'b1;
          div_start = 1'b1;
          state_nxt = BK_DIV_H;
        end
      end
      BK_DIV_H: begin
        div_num = RW'(y_r) * RW'(V_DROP);
        div_den = DVW'(hm1);
        if (div_done) begin
          ld_h6     = 1'b1;
          div_start = 1'b1;
          state_nxt = BK_DIV_V;
        end
      end
      BK_DIV_V: begin
        if (div_done) begin
          ld_v      = 1'b1;
          state_nxt = BK_MUL_C;
        end
      end
      BK_MUL_C: begin
        ld_c      = 1'b1;
        state_nxt = BK_MUL_MID;
      end
      BK_MUL_MID: begin
        ld_mid    = 1'b1;
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          ld_out    = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign prod_c = {{Q12_W{1'b0}}, v_r} * {{Q12_W{1'b0}}, sat};
  assign fsel   = h6_r[12] ? (Q12_ONE - {1'b0, h6_r[11:0]}) : {1'b0, h6_r[11:0]};
  assign prod_m = {{Q12_W{1'b0}}, c_r} * {{Q12_W{1'b0}}, fsel};

  always_comb begin
    unique case (h6_r[14:12])
      3'd0:    begin r1 = c_r;   g1 = mid_r; b1 = '0;    end
      3'd1:    begin r1 = mid_r; g1 = c_r;   b1 = '0;    end
      3'd2:    begin r1 = '0;    g1 = c_r;   b1 = mid_r; end
      3'd3:    begin r1 = '0;    g1 = mid_r; b1 = c_r;   end
      3'd4:    begin r1 = mid_r; g1 = '0;    b1 = c_r;   end
      default: begin r1 = c_r;   g1 = '0;    b1 = mid_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_item) begin
      y_r     <= qy;
      flags_r <= qf;
    end
    if (ld_h6) begin
      h6_r <= (div_quo >= HUE_SPAN) ? div_quo - HUE_SPAN : div_quo;
    end
    if (ld_v) begin
      v_r <= Q12_ONE - div_quo[Q12_W-1:0];
    end
    if (ld_c) begin
      c_r <= prod_c[Q12_W+11:12];
    end
    if (ld_mid) begin
      mid_r <= prod_m[Q12_W+11:12];
      m_r   <= v_r - c_r;
    end
    if (ld_out) begin
      red_r    <= to_byte(r1 + m_r);
      green_r  <= to_byte(g1 + m_r);
      blue_r   <= to_byte(b1 + m_r);
      oflags_r <= flags_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.red          = red_r;
  assign out_chan.green        = green_r;
  assign out_chan.blue         = blue_r;
  assign out_chan.end_of_line  = oflags_r.eol;
  assign out_chan.end_of_frame = oflags_r.eof;

endmodule

`default_nettype wire

@@ rtl/hsv_gradient_pattern_generator.sv @@
// Top level: HSV gradient raster test-pattern generator.
//
// Each transfer on in_chan requests one pixel; each transfer on out_chan
// returns it as 8-bit red/green/blue plus end_of_line / end_of_frame flags.
// restart_frame = 1 restarts the raster at pixel (0,0) before that pixel.
// Hue sweeps the color circle across a row; value falls from 1.0 at the top
// row to 0.4 at the bottom row; saturation comes from a register.
// cfg_we/cfg_index/cfg_wdata write line_width (0), frame_height (1) and
// saturation (2); other indexes are ignored. Write only while idle.
// A two-entry queue decouples the request side from the color math, so
// requests are taken while a pixel is being computed or waits on out_chan.
// The back end takes one queued pixel at a time: hue division, value
// division, chroma and mid products, then the output register. The shared
// 15-step divider runs once for hue and once for value per pixel.
// Reset (rst_n low, synchronous) restores 800x200, full saturation and the
// raster position (0,0), and empties the queue. When out_chan stalls the
// pixel holds; up to three more requests are absorbed before in_chan.ready
// drops.
`timescale 1ns / 1ps
`default_nettype none

module hsv_gradient_pattern_generator import hgp_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  hgp_in_if.sink               in_chan,
  hgp_out_if.source            out_chan
);

  localparam int WCAP   = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP;
  localparam int HCAP   = (MAX_HEIGHT < DIM_CAP) ? MAX_HEIGHT : DIM_CAP;
  localparam int XW     = $clog2(WCAP);
  localparam int YW     = $clog2(HCAP);
  localparam int DVW    = (XW > YW) ? XW : YW;
  localparam int RW     = DVW + QUO_W;
  localparam int QDW    = XW + YW + 2;
  localparam int QDEPTH = 2;

  logic [CFG_W-1:0] line_width_r, frame_height_r, saturation_r;
  logic [CFG_W-1:0] wm1_full, hm1_full;
  logic [XW-1:0]    wm1;
  logic [YW-1:0]    hm1;
  logic [Q12_W-1:0] sat_eff;

  logic             q_push, q_full, q_valid, q_pop;
  logic [QDW-1:0]   q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= RST_LINE_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      saturation_r   <= RST_SATURATION;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH:   line_width_r   <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        CFG_SATURATION:   saturation_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_width_r < 13'd2) begin
      wm1_full = 13'd1;
    end else if (line_width_r > CFG_W'(WCAP)) begin
      wm1_full = CFG_W'(WCAP - 1);
    end else begin
      wm1_full = line_width_r - 13'd1;
    end
    if (frame_height_r < 13'd2) begin
      hm1_full = 13'd1;
    end else if (frame_height_r > CFG_W'(HCAP)) begin
      hm1_full = CFG_W'(HCAP - 1);
    end else begin
      hm1_full = frame_height_r - 13'd1;
    end
  end

  assign wm1     = wm1_full[XW-1:0];
  assign hm1     = hm1_full[YW-1:0];
  assign sat_eff = (saturation_r > Q12_ONE) ? Q12_ONE : saturation_r;

  hgp_front #(.XW(XW), .YW(YW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .wm1     (wm1),
    .hm1     (hm1),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  hgp_fifo #(.DW(QDW), .DEPTH(QDEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .rdata (q_rdata)
  );

  hgp_back #(.XW(XW), .YW(YW), .DVW(DVW), .RW(RW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .wm1      (wm1),
    .hm1      (hm1),
    .sat      (sat_eff),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

@@ rtl/hgp_checker.sv @@
// Port-level assertions for the pattern generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hgp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_eol,
  input logic       out_eof
);

  logic [2:0] pend_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_xfer && !out_xfer) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  a_no_spurious_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("pixel presented without an outstanding request");

  a_eof_is_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_eof |-> out_eol)
    else $error("end of frame without end of line");

  a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable({out_red, out_green, out_blue, out_eol, out_eof}))
    else $error("stalled pixel changed");

endmodule

bind hsv_gradient_pattern_generator hgp_checker u_hgp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_red   (out_chan.red),
  .out_green (out_chan.green),
  .out_blue  (out_chan.blue),
  .out_eol   (out_chan.end_of_line),
  .out_eof   (out_chan.end_of_frame)
);

`default_nettype wire
